// File: rtl/referee_frame_field_extractor_top_macros.svh
// assertion macros shared by the rtl
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef REFEREE_FRAME_FIELD_EXTRACTOR_TOP_MACROS_SVH
`define REFEREE_FRAME_FIELD_EXTRACTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// plain property, checked at every rising edge of clk_i
`define RFFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RFFE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RFFE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RFFE_ASSERT(lbl, prop, msg)
`define RFFE_ASSERT_IMP(lbl, ante, cons, msg)
`define RFFE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/rffe_pkg.sv
package rffe_pkg;

  // matcher and store geometry
  localparam int NumMatchers = 4;
  localparam int MatchAw     = $clog2(NumMatchers);
  localparam int StoreDepth  = 43;
  localparam int StoreAw     = $clog2(StoreDepth);
  localparam int CountW      = 5;

  // header bytes
  localparam logic [7:0]        StartByte = 8'hA5;
  localparam logic [CountW-1:0] SkipCount = CountW'(2);

  // power buffer clamp limits (60.0f and +inf)
  localparam logic [31:0] BufferLimitBits = 32'h4270_0000;
  localparam logic [31:0] FloatInfBits    = 32'h7F80_0000;

  // per-matcher header codes and store regions
  localparam logic [7:0] LenCode [NumMatchers] = '{8'h08, 8'h01, 8'h06, 8'h14};
  localparam logic [7:0] CmdCode [NumMatchers] = '{8'h01, 8'h02, 8'h03, 8'h04};
  localparam logic [StoreAw-1:0] RegionBase [NumMatchers] =
    '{StoreAw'(0), StoreAw'(10), StoreAw'(13), StoreAw'(21)};
  localparam logic [CountW-1:0] RegionLen [NumMatchers] =
    '{CountW'(10), CountW'(3), CountW'(8), CountW'(22)};

  // store write request from one matcher
  typedef struct packed {
    logic              en;
    logic [CountW-1:0] offset;
  } store_wr_t;

  // decoded result fields
  typedef struct packed {
    logic [15:0] max_health;
    logic [7:0]  robot_level;
    logic [7:0]  projectile_type;
    logic [7:0]  fire_rate;
    logic [31:0] projectile_speed_bits;
    logic [31:0] chassis_voltage_bits;
    logic [31:0] chassis_current_bits;
    logic [31:0] chassis_power_bits;
    logic [31:0] power_buffer_bits;
    logic [15:0] small_barrel_heat;
    logic [15:0] large_barrel_heat;
  } result_t;

  // matcher that owns a given store entry
  function automatic logic [MatchAw-1:0] owner_of(input int idx);
    logic [MatchAw-1:0] owner;
    owner = '0;
    for (int m = 0; m < NumMatchers; m++) begin
      if (idx >= int'(RegionBase[m])) begin
        owner = MatchAw'(m);
      end
    end
    return owner;
  endfunction

endpackage

// File: rtl/referee_frame_field_extractor_top.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------
// in       | sink      | in_valid_i / in_stall_o | byte_in_i
// out      | source    | out_valid_o/out_stall_i | decoded fields, one per byte
//
// one byte per cycle sustained while out is not stalled;
// the byte register feeds the matchers, the result register holds the decoded fields
// reset clears the matchers, the 43-byte store and both valid flags at once
// while out is stalled a held byte waits in the input register, and in stalls
// only when that register is full and the result register cannot drain
`include "referee_frame_field_extractor_top_macros.svh"

module referee_frame_field_extractor_top
  import rffe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] max_health_o,
  output logic [7:0]  robot_level_o,
  output logic [7:0]  projectile_type_o,
  output logic [7:0]  fire_rate_o,
  output logic [31:0] projectile_speed_bits_o,
  output logic [31:0] chassis_voltage_bits_o,
  output logic [31:0] chassis_current_bits_o,
  output logic [31:0] chassis_power_bits_o,
  output logic [31:0] power_buffer_bits_o,
  output logic [15:0] small_barrel_heat_o,
  output logic [15:0] large_barrel_heat_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  result_t    res_q, res_d;
  logic       adv;
  logic       proc;
  store_wr_t  wr [NumMatchers];
  logic [NumMatchers-1:0] wr_en;

  // pipeline control
  assign adv        = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_in_i;
    end
  end

  // four header matchers
  for (genvar m = 0; m < NumMatchers; m++) begin : g_match
    rffe_matcher u_matcher (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (proc),
      .byte_i       (byte_q),
      .len_code_i   (LenCode[m]),
      .cmd_code_i   (CmdCode[m]),
      .region_len_i (RegionLen[m]),
      .wr_o         (wr[m])
    );
    assign wr_en[m] = wr[m].en;
  end

  // payload store and field decode
  rffe_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .byte_i (byte_q),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign max_health_o            = res_q.max_health;
  assign robot_level_o           = res_q.robot_level;
  assign projectile_type_o       = res_q.projectile_type;
  assign fire_rate_o             = res_q.fire_rate;
  assign projectile_speed_bits_o = res_q.projectile_speed_bits;
  assign chassis_voltage_bits_o  = res_q.chassis_voltage_bits;
  assign chassis_current_bits_o  = res_q.chassis_current_bits;
  assign chassis_power_bits_o    = res_q.chassis_power_bits;
  assign power_buffer_bits_o     = res_q.power_buffer_bits;
  assign small_barrel_heat_o     = res_q.small_barrel_heat;
  assign large_barrel_heat_o     = res_q.large_barrel_heat;

  // store is written only for a byte that is being processed
  `RFFE_ASSERT_IMP(a_wr_only_on_proc, |wr_en, proc, "store write without a processed byte")

  // a new result comes only from a held byte
  `RFFE_ASSERT_IMP(a_out_from_in, $rose(out_valid_q), $past(in_valid_q),
                   "result without a byte")

  // a delivered power buffer above 60.0 must be nan or negative
  `RFFE_ASSERT(a_buf_clamped,
               !out_valid_q || power_buffer_bits_o[31] ||
               (power_buffer_bits_o <= BufferLimitBits) ||
               (power_buffer_bits_o > FloatInfBits),
               "power buffer not clamped")

  // a processed byte always yields a valid result next cycle
  `RFFE_ASSERT_NXT(a_proc_to_out, proc, out_valid_q, "processed byte lost")

endmodule

// File: rtl/rffe_matcher.sv
module rffe_matcher
  import rffe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        byte_i,
  input  logic [7:0]        len_code_i,
  input  logic [7:0]        cmd_code_i,
  input  logic [CountW-1:0] region_len_i,
  output store_wr_t         wr_o
);

  typedef enum logic [2:0] {
    PhStart,
    PhLength,
    PhZeroA,
    PhSkip,
    PhCommand,
    PhZeroB,
    PhPayload
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] cnt_inc;

  assign cnt_inc = cnt_q + CountW'(1);

  // header walk and payload offset
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    wr_o.en     = 1'b0;
    wr_o.offset = cnt_q;
    unique case (phase_q)
      PhStart:   phase_d = (byte_i == StartByte) ? PhLength : PhStart;
      PhLength:  phase_d = (byte_i == len_code_i) ? PhZeroA : PhStart;
      PhZeroA:   phase_d = (byte_i == 8'h00) ? PhSkip : PhStart;
      PhSkip: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= SkipCount) begin
          phase_d = PhCommand;
          cnt_d   = '0;
        end
      end
      PhCommand: phase_d = (byte_i == cmd_code_i) ? PhZeroB : PhStart;
      PhZeroB:   phase_d = (byte_i == 8'h00) ? PhPayload : PhStart;
      PhPayload: begin
        wr_o.en = adv_i && (cnt_q < region_len_i);
        cnt_d   = cnt_inc;
        if (cnt_inc >= region_len_i) begin
          phase_d = PhStart;
          cnt_d   = '0;
        end
      end
      default:   phase_d = PhStart;
    endcase
  end

  // state, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      cnt_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/rffe_store.sv
module rffe_store
  import rffe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_wr_t  wr_i [NumMatchers],
  input  logic [7:0] byte_i,
  output result_t    res_o
);

  logic [7:0]            store_q [StoreDepth];
  logic [7:0]            store_d [StoreDepth];
  logic [StoreDepth-1:0] hit;
  logic [31:0]           buf_raw;

  // each entry belongs to exactly one matcher region
  for (genvar i = 0; i < StoreDepth; i++) begin : g_entry
    localparam logic [MatchAw-1:0] Owner  = owner_of(i);
    localparam logic [CountW-1:0]  Offset = CountW'(i - int'(RegionBase[Owner]));
    assign hit[i] = wr_i[Owner].en && (wr_i[Owner].offset == Offset);
  end

  // store contents after this byte
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      store_d[i] = hit[i] ? byte_i : store_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      store_q <= store_d;
    end
  end

  // little-endian field decode from the updated store
  assign buf_raw = {store_d[36], store_d[35], store_d[34], store_d[33]};

  always_comb begin
    res_o.max_health            = {store_d[7], store_d[6]};
    res_o.robot_level           = store_d[3];
    res_o.projectile_type       = store_d[13];
    res_o.fire_rate             = store_d[14];
    res_o.projectile_speed_bits = {store_d[18], store_d[17], store_d[16], store_d[15]};
    res_o.chassis_voltage_bits  = {store_d[24], store_d[23], store_d[22], store_d[21]};
    res_o.chassis_current_bits  = {store_d[28], store_d[27], store_d[26], store_d[25]};
    res_o.chassis_power_bits    = {store_d[32], store_d[31], store_d[30], store_d[29]};
    res_o.small_barrel_heat     = {store_d[38], store_d[37]};
    res_o.large_barrel_heat     = {store_d[40], store_d[39]};
    // positive values above 60.0 up to +inf clamp, nan and negatives pass
    if (!buf_raw[31] && (buf_raw > BufferLimitBits) && (buf_raw <= FloatInfBits)) begin
      res_o.power_buffer_bits = BufferLimitBits;
    end else begin
      res_o.power_buffer_bits = buf_raw;
    end
  end

endmodule
